// ===== rtl/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

  // Fixed lane width of each field on the input stream port.
  localparam int FIELD_BITS = 32;
  localparam int IN_BITS    = 6 * FIELD_BITS;
  localparam int COUNT_BITS = 33;
  localparam int OUT_BITS   = 40;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_DELTA,
    S_DELTA_W,
    S_GCD,
    S_GCD_W,
    S_DG,
    S_DG_W,
    S_N,
    S_N_W,
    S_D2G,
    S_D2G_W,
    S_A,
    S_A_W,
    S_B,
    S_B_W,
    S_INV0,
    S_INV,
    S_INV_W,
    S_INVM,
    S_INVU,
    S_INVF,
    S_M1,
    S_M2,
    S_M2_W,
    S_OFF,
    S_LCM,
    S_CMP,
    S_CNT_W,
    S_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  // Status from the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/progression_coincidence_count_top.sv =====
`timescale 1ns / 1ps

// Counts the values hit by both of two arithmetic progressions in their overlap.
// Input channel s_*: one item holds start_a, start_b, bound_a, bound_b, stride_a
// and stride_b, each in a 32-bit lane of s_tdata. Output channel m_*: one item per
// input item with hit_count in m_tdata and bad_stride in m_tuser.
// Each item is worked by a sequencer around one shared restoring divider (one
// quotient bit per cycle) and one registered multiplier. Only one division per
// item, that of the multiplier product, is wide; all the others are narrow.
// The sequencer runs through the gcd rounds and the extended Euclid rounds before
// it counts, and it takes the next item only after it has returned to idle.
// Zero strides and an empty overlap go from the setup step straight to output.
// s_tready is high only while the sequencer is idle, also while a finished result
// still waits on the output register. If the receiver stalls, the result is held
// and the next item's result waits until the output register is free.
// Reset (rst, synchronous, active high) empties the output register and returns
// the sequencer to idle.

module progression_coincidence_count_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // start_a[31:0], start_b[63:32], bound_a[95:64], bound_b[127:96],
  // stride_a[159:128], stride_b[191:160]
  input  logic [pcc_pkg::IN_BITS-1:0]    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hit_count[32:0], zeros above
  output logic [pcc_pkg::OUT_BITS-1:0]   m_tdata,
  // bad_stride[0]
  output logic                           m_tuser
);
  import pcc_pkg::*;

  localparam int W  = VALUE_BITS;
  localparam int DW = 2 * VALUE_BITS;
  localparam int SW = VALUE_BITS + 2;
  localparam int PW = 2 * VALUE_BITS + 4;

  state_t state;
  state_t state_next;

  // Item registers.
  logic [W-1:0] in_sa, in_sb, in_ha, in_hb, in_da, in_db;
  logic [W-1:0] sa, d1, d2, lo, hi, delta;
  logic [W-1:0] ga, gb, g, dg, n, d2g, av, bv, r0, r1, qv, inv, m;
  logic signed [SW-1:0] s0, s1;
  logic [DW-1:0] offset;
  logic [W:0]    count;

  // Output register.
  logic [COUNT_BITS-1:0] hit_count;
  logic                  bad_stride;

  // Shared unit hookup.
  div_req_t             div_req;
  div_stat_t            div_stat;
  logic [DW-1:0]        div_dvd, div_dvs, div_quo, div_rem;
  logic signed [SW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  // Helper values for the setup and finishing steps.
  logic          swap;
  logic [W-1:0]  span;
  logic signed [SW-1:0] s0_pos;
  logic [SW-1:0] inv_full;
  logic          out_free;

  assign swap     = (in_sb < in_sa);
  assign span     = hi - lo;
  assign s0_pos   = s0[SW-1] ? (s0 + $signed({2'b00, n})) : s0;
  assign inv_full = (s0_pos >= $signed({2'b00, n})) ? SW'(s0_pos - $signed({2'b00, n}))
                                                     : SW'(s0_pos);
  assign out_free = !m_tvalid || m_tready;

  // Offset fits in the span when it is no larger than it.
  function automatic logic prod_low_ok(input logic [DW-1:0] off, input logic [W-1:0] sp);
    prod_low_ok = (off <= {{(DW-W){1'b0}}, sp});
  endfunction

  pcc_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  pcc_mul #(.VALUE_BITS(VALUE_BITS)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_tvalid) state_next = S_SETUP;
      S_SETUP: begin
        if (in_da == '0 || in_db == '0) begin
          state_next = S_OUT;
        end else if ((in_ha < in_hb ? in_ha : in_hb) < (swap ? in_sa : in_sb)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_DELTA;
        end
      end
      S_DELTA:   state_next = S_DELTA_W;
      S_DELTA_W: if (div_stat.done) state_next = S_GCD;
      S_GCD:     state_next = (gb == '0) ? S_DG : S_GCD_W;
      S_GCD_W:   if (div_stat.done) state_next = S_GCD;
      S_DG:      state_next = S_DG_W;
      S_DG_W: begin
        if (div_stat.done) state_next = (div_rem != '0) ? S_OUT : S_N;
      end
      S_N:       state_next = S_N_W;
      S_N_W:     if (div_stat.done) state_next = S_D2G;
      S_D2G:     state_next = S_D2G_W;
      S_D2G_W:   if (div_stat.done) state_next = S_A;
      S_A:       state_next = S_A_W;
      S_A_W:     if (div_stat.done) state_next = S_B;
      S_B:       state_next = S_B_W;
      S_B_W:     if (div_stat.done) state_next = S_INV0;
      S_INV0:    state_next = (n <= W'(1)) ? S_M1 : S_INV;
      S_INV:     state_next = (r1 == '0) ? S_INVF : S_INV_W;
      S_INV_W:   if (div_stat.done) state_next = S_INVM;
      S_INVM:    state_next = S_INVU;
      S_INVU:    state_next = S_INV;
      S_INVF:    state_next = S_M1;
      S_M1:      state_next = S_M2;
      S_M2:      state_next = S_M2_W;
      S_M2_W:    if (div_stat.done) state_next = S_OFF;
      S_OFF:     state_next = S_LCM;
      S_LCM:     state_next = S_CMP;
      S_CMP:     state_next = (prod_low_ok(offset, span)) ? S_CNT_W : S_OUT;
      S_CNT_W:   if (div_stat.done) state_next = S_OUT;
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Shared unit controls.
  always_comb begin
    div_req.start = 1'b0;
    div_req.wide  = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      S_DELTA: begin
        div_req.start = 1'b1;
        div_dvd       = DW'(lo - sa);
        div_dvs       = DW'(d1);
      end
      S_GCD: begin
        div_req.start = (gb != '0);
        div_dvd       = DW'(ga);
        div_dvs       = DW'(gb);
      end
      S_DG: begin
        div_req.start = 1'b1;
        div_dvd       = DW'(delta);
        div_dvs       = DW'(g);
      end
      S_N: begin
        div_req.start = 1'b1;
        div_dvd       = DW'(d1);
        div_dvs       = DW'(g);
      end
      S_D2G: begin
        div_req.start = 1'b1;
        div_dvd       = DW'(d2);
        div_dvs       = DW'(g);
      end
      S_A: begin
        div_req.start = 1'b1;
        div_dvd       = DW'(d2g);
        div_dvs       = DW'(n);
      end
      S_B: begin
        div_req.start = 1'b1;
        div_dvd       = DW'(dg);
        div_dvs       = DW'(n);
      end
      S_INV: begin
        div_req.start = (r1 != '0);
        div_dvd       = DW'(r0);
        div_dvs       = DW'(r1);
      end
      S_INVM: begin
        mul_a = $signed({2'b00, qv});
        mul_b = s1;
      end
      S_M1: begin
        mul_a = $signed({2'b00, bv});
        mul_b = $signed({2'b00, inv});
      end
      S_M2: begin
        div_req.start = 1'b1;
        div_req.wide  = 1'b1;
        div_dvd       = prod[DW-1:0];
        div_dvs       = DW'(n);
      end
      S_OFF: begin
        mul_a = $signed({2'b00, d2});
        mul_b = $signed({2'b00, m});
      end
      S_LCM: begin
        mul_a = $signed({2'b00, n});
        mul_b = $signed({2'b00, d2});
      end
      S_CMP: begin
        div_req.start = prod_low_ok(offset, span);
        div_dvd       = DW'(span - offset[W-1:0]);
        div_dvs       = prod[DW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        in_sa <= s_tdata[0*FIELD_BITS +: W];
        in_sb <= s_tdata[1*FIELD_BITS +: W];
        in_ha <= s_tdata[2*FIELD_BITS +: W];
        in_hb <= s_tdata[3*FIELD_BITS +: W];
        in_da <= s_tdata[4*FIELD_BITS +: W];
        in_db <= s_tdata[5*FIELD_BITS +: W];
      end
      S_SETUP: begin
        sa    <= swap ? in_sb : in_sa;
        d1    <= swap ? in_db : in_da;
        d2    <= swap ? in_da : in_db;
        lo    <= swap ? in_sa : in_sb;
        hi    <= (in_ha < in_hb) ? in_ha : in_hb;
        ga    <= swap ? in_db : in_da;
        gb    <= swap ? in_da : in_db;
        count <= '0;
      end
      S_DELTA_W: begin
        if (div_stat.done) delta <= (div_rem[W-1:0] == '0) ? '0 : d1 - div_rem[W-1:0];
      end
      S_GCD: begin
        g <= ga;
      end
      S_GCD_W: begin
        if (div_stat.done) begin
          ga <= gb;
          gb <= div_rem[W-1:0];
        end
      end
      S_DG_W:  if (div_stat.done) dg  <= div_quo[W-1:0];
      S_N_W:   if (div_stat.done) n   <= div_quo[W-1:0];
      S_D2G_W: if (div_stat.done) d2g <= div_quo[W-1:0];
      S_A_W:   if (div_stat.done) av  <= div_rem[W-1:0];
      S_B_W:   if (div_stat.done) bv  <= div_rem[W-1:0];
      S_INV0: begin
        inv <= '0;
        r0  <= n;
        r1  <= av;
        s0  <= '0;
        s1  <= SW'(1);
      end
      S_INV_W: begin
        if (div_stat.done) begin
          qv <= div_quo[W-1:0];
          r0 <= r1;
          r1 <= div_rem[W-1:0];
        end
      end
      S_INVU: begin
        s0 <= s1;
        s1 <= SW'(s0 - prod[SW-1:0]);
      end
      S_INVF:  inv    <= inv_full[W-1:0];
      S_M2_W:  if (div_stat.done) m <= div_rem[W-1:0];
      S_LCM:   offset <= prod[DW-1:0];
      S_CNT_W: if (div_stat.done) count <= (W+1)'(div_quo[W-1:0]) + 1'b1;
      default: begin
      end
    endcase
  end

  // Output register; the bad-stride flag forces a zero count.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      bad_stride <= (in_da == '0 || in_db == '0);
      hit_count  <= (in_da == '0 || in_db == '0) ? '0 : COUNT_BITS'(count);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(OUT_BITS-COUNT_BITS){1'b0}}, hit_count};
  assign m_tuser  = bad_stride;

  // The divider is never left running while the sequencer is idle.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while idle");

  // A bad stride always reports a zero count.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> hit_count == '0)
    else $error("nonzero count with bad stride");

  // The count stays below two to the power of the value width plus one.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hit_count >> (W + 1)) == '0)
    else $error("count out of range");

  // A division is only started from the sequencer's issue steps with the unit free.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy && state != S_IDLE)
    else $error("divider started while busy");

endmodule

// ===== rtl/pcc_div.sv =====
`timescale 1ns / 1ps

module pcc_div #(
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pcc_pkg::div_req_t         req,
  input  logic [2*VALUE_BITS-1:0]   dividend,
  input  logic [2*VALUE_BITS-1:0]   divisor,
  output pcc_pkg::div_stat_t        stat,
  output logic [2*VALUE_BITS-1:0]   quo,
  output logic [2*VALUE_BITS-1:0]   rem
);
  import pcc_pkg::*;

  localparam int W  = VALUE_BITS;
  localparam int DW = 2 * VALUE_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic          fits;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign trial = {rem, quo[DW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // Control state of the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.wide ? CW'(DW) : CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider; a narrow dividend is aligned to the top.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= req.wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/pcc_mul.sv =====
`timescale 1ns / 1ps

module pcc_mul #(
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic signed [VALUE_BITS+1:0]     op_a,
  input  logic signed [VALUE_BITS+1:0]     op_b,
  output logic signed [2*VALUE_BITS+3:0]   prod
);
  import pcc_pkg::*;

  // Signed multiply with a registered product, ready in the next cycle.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ===== sim/tb_progression_coincidence_count_top.sv =====
`timescale 1ns / 1ps

module tb_progression_coincidence_count_top;
  import pcc_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int NUM_RANDOM = 350;
  localparam int HOLD_CYCLES = 10000;

  typedef struct {
    logic [31:0] start_a;
    logic [31:0] start_b;
    logic [31:0] bound_a;
    logic [31:0] bound_b;
    logic [31:0] stride_a;
    logic [31:0] stride_b;
  } progression_pair_t;

  typedef struct {
    logic [32:0] hit_count;
    logic        bad_stride;
  } coincidence_t;

  // One row of the directed table: the item, and its result where it is obvious.
  typedef struct {
    progression_pair_t pair;
    bit                known;
    coincidence_t      result;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;
  logic                m_tuser;

  coincidence_t  pending_counts[$];
  int            fail_count = 0;
  int            results_seen = 0;
  bit            sending_done = 1'b0;
  directed_row_t directed_rows[$];

  progression_coincidence_count_top #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Modular inverse by extended Euclid, with signed coefficients.
  function automatic longint unsigned mod_inverse(longint unsigned a, longint unsigned n);
    longint r0, r1, c0, c1, q, t;
    if (n <= 1) return 0;
    r0 = longint'(n);
    r1 = longint'(a % n);
    c0 = 0;
    c1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1;
      r0 = r1;
      r1 = t;
      t = c0 - q * c1;
      c0 = c1;
      c1 = t;
    end
    if (c0 < 0) c0 += longint'(n);
    return longint'(c0) % n;
  endfunction

  // Number of values that both progressions hit within their overlap.
  function automatic coincidence_t count_coincidences(progression_pair_t p);
    coincidence_t res;
    longint unsigned s1, s2, h1, h2, d1, d2, lo, hi, gap, g, x, y, r, n, m, offset, lcm;
    res.hit_count = '0;
    res.bad_stride = 1'b0;
    s1 = p.start_a; s2 = p.start_b;
    h1 = p.bound_a; h2 = p.bound_b;
    d1 = p.stride_a; d2 = p.stride_b;
    if (d1 == 0 || d2 == 0) begin
      res.bad_stride = 1'b1;
      return res;
    end
    // The earlier start leads; A leads on equal starts.
    if (s2 < s1) begin
      {s1, s2} = {s2, s1};
      {h1, h2} = {h2, h1};
      {d1, d2} = {d2, d1};
    end
    lo = s2;
    hi = (h1 < h2) ? h1 : h2;
    if (hi < lo) return res;
    gap = (d1 - ((lo - s1) % d1)) % d1;
    x = d1;
    y = d2;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    g = x;
    if (gap % g != 0) return res;
    n = d1 / g;
    m = ((gap / g) % n) * mod_inverse((d2 / g) % n, n) % n;
    offset = d2 * m;
    lcm = n * d2;
    if (offset <= hi - lo) res.hit_count = 33'((hi - lo - offset) / lcm + 1);
    return res;
  endfunction

  function automatic directed_row_t make_row(logic [31:0] sa, logic [31:0] sb,
                                             logic [31:0] ba, logic [31:0] bb,
                                             logic [31:0] da, logic [31:0] db,
                                             bit known, logic [32:0] cnt, logic bad);
    directed_row_t row;
    row.pair = '{sa, sb, ba, bb, da, db};
    row.known = known;
    row.result.hit_count = cnt;
    row.result.bad_stride = bad;
    return row;
  endfunction

  // Random item: mostly well-formed overlapping progressions, some noise.
  function automatic progression_pair_t random_pair();
    progression_pair_t p;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind < 20) begin
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3), $urandom_range(0, 3)};
      if ($urandom_range(0, 1)) p.stride_a = '0;
      else p.stride_b = '0;
    end else if (kind < 35) begin
      // Large strides over wide ranges.
      p.start_a = $urandom_range(0, 32'h0FFF_FFFF);
      p.start_b = $urandom_range(0, 32'h0FFF_FFFF);
      p.bound_a = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
      p.bound_b = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
      p.stride_a = $urandom_range(1, 32'h00FF_FFFF);
      p.stride_b = $urandom_range(1, 32'h000F_FFFF);
    end else begin
      p.start_a = $urandom;
      p.start_b = p.start_a + $urandom_range(0, 2000);
      if ($urandom_range(0, 1)) {p.start_a, p.start_b} = {p.start_b, p.start_a};
      p.stride_a = $urandom_range(1, $urandom_range(1, 1000));
      p.stride_b = $urandom_range(1, $urandom_range(1, 1000));
      p.bound_a = p.start_a + $urandom_range(0, 200000);
      p.bound_b = p.start_b + $urandom_range(0, 200000);
      if (p.bound_a < p.start_a) p.bound_a = '1;
      if (p.bound_b < p.start_b) p.bound_b = '1;
    end
    return p;
  endfunction

  // Offer one item after a random gap (none when no_gaps is set), and record its result once accepted.
  task automatic offer_item(progression_pair_t p, coincidence_t res, bit no_gaps);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 80);
      else gap = $urandom_range(0, 2);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p.stride_b, p.stride_a, p.bound_b, p.bound_a, p.start_b, p.start_a};
    do @(posedge clk); while (!s_tready);
    pending_counts.push_back(res);
  endtask

  // Sender: directed table first, then random items.
  initial begin
    progression_pair_t p;
    coincidence_t res;
    directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(make_row(1, 2, 100, 100, 0, 3, 1, 0, 1));
    directed_rows.push_back(make_row(1, 2, 100, 100, 3, 0, 1, 0, 1));
    directed_rows.push_back(make_row('1, '1, '1, '1, 0, 0, 1, 0, 1));
    directed_rows.push_back(make_row('1, '1, '1, '1, '1, '1, 1, 1, 0));
    directed_rows.push_back(make_row(0, 0, '1, '1, 1, 1, 1, 33'h1_0000_0000, 0));
    directed_rows.push_back(make_row(100, 10, 50, 200, 1, 1, 1, 0, 0));
    directed_rows.push_back(make_row(10, 100, 200, 50, 1, 1, 1, 0, 0));
    directed_rows.push_back(make_row(0, 1, 100, 100, 2, 2, 1, 0, 0));
    directed_rows.push_back(make_row(0, 1, 5, 5, 10, 3, 1, 0, 0));
    directed_rows.push_back(make_row(5, 5, 100, 100, 3, 5, 0, 0, 0));
    directed_rows.push_back(make_row(7, 3, 1000, 900, 4, 6, 0, 0, 0));
    directed_rows.push_back(make_row(3, 7, 900, 1000, 6, 4, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, '1, '1, '1, 1, 0, 0, 0));
    directed_rows.push_back(make_row(0, 1, '1, '1, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    directed_rows.push_back(make_row(12, 40, 100000, 90000, 17, 29, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, 0, 0, 1, 1, 0, 0, 0));
    directed_rows.push_back(make_row(2, 0, '1, '1, 89, 55, 0, 0, 0));
    directed_rows.push_back(make_row(0, 5, '1, 5, 1, '1, 0, 0, 0));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      res = directed_rows[i].known ? directed_rows[i].result
                                   : count_coincidences(directed_rows[i].pair);
      offer_item(directed_rows[i].pair, res, 1'b0);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      p = random_pair();
      offer_item(p, count_coincidences(p), (i >= 150 && i < 190));
    end
    s_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: checks each result, stalls at random, and holds off once for a long stretch.
  initial begin
    coincidence_t want;
    bit held;
    int hold_left;
    held = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_counts.size() == 0) begin
          $error("unexpected result: hit_count %0d bad_stride %0b", m_tdata[32:0], m_tuser);
          fail_count++;
        end else begin
          want = pending_counts.pop_front();
          if (m_tdata[32:0] !== want.hit_count) begin
            $error("hit_count: expected %0d, got %0d", want.hit_count, m_tdata[32:0]);
            fail_count++;
          end
          if (m_tuser !== want.bad_stride) begin
            $error("bad_stride: expected %0b, got %0b", want.bad_stride, m_tuser);
            fail_count++;
          end
          if (m_tdata[OUT_BITS-1:33] !== '0) begin
            $error("m_tdata padding: expected 0, got %0h", m_tdata[OUT_BITS-1:33]);
            fail_count++;
          end
        end
      end
      if (!held && results_seen == 120) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (results_seen >= 200 && results_seen < 240) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        hold_left = $urandom_range(30, 120);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // End of run once every result has arrived.
  initial begin
    wait (sending_done);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_progression_coincidence_count_top: PASS");
    end else begin
      $display("tb_progression_coincidence_count_top: FAIL");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #80_000_000;
    $display("tb_progression_coincidence_count_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pcc_pkg.sv
rtl/pcc_div.sv
rtl/pcc_mul.sv
rtl/progression_coincidence_count_top.sv
sim/tb_progression_coincidence_count_top.sv
